// ===== design/bmpfb_pkg.sv =====
package bmpfb_pkg;

   // image limits and framebuffer size
   localparam int MAX_DIM  = 2048;
   localparam int FB_WORDS = 1048576;

   // bmp header layout
   localparam int HDR_BYTES = 54;
   localparam int W_OFS     = 18;
   localparam int H_OFS     = 22;
   // dimensions are settled once both header words are in
   localparam int DIM_AT    = H_OFS + 4;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int PIX_W   = 3 * BYTE_W;
   localparam int HDR_W   = $clog2(HDR_BYTES + 1);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int COL_W   = $clog2(MAX_DIM);
   localparam int SROW_W  = 11;
   localparam int SCOL_W  = 11;
   localparam int LW_W    = 12;
   localparam int FROW_W  = ((SROW_W > DIM_W) ? SROW_W : DIM_W) + 1;
   localparam int PROD_W  = FROW_W + LW_W;
   localparam int ADDR_W  = PROD_W + 1;
   localparam int FBA_W   = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_ROW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_COL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 2'd2;

   localparam logic [LW_W-1:0] LINE_WIDTH_RST = 12'd640;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [SROW_W-1:0] top_row;
      logic [SCOL_W-1:0] left_col;
      logic [LW_W-1:0]   line_width;
   } bmpfb_cfg_type;

   // one unit of work for the back end
   typedef struct packed {
      logic              has_pixel;
      logic              new_row;
      logic [FROW_W-1:0] frame_row;
      logic [LW_W-1:0]   line_width;
      logic [SCOL_W-1:0] left_col;
      logic [COL_W-1:0]  column;
      logic [PIX_W-1:0]  pixel;
      logic              last;
   } bmpfb_entry_type;

   // entry after the multiplier stage
   typedef struct packed {
      logic              has_pixel;
      logic              new_row;
      logic [SCOL_W-1:0] left_col;
      logic [COL_W-1:0]  column;
      logic [PIX_W-1:0]  pixel;
      logic              last;
   } bmpfb_stage_type;

endpackage

// ===== design/bmpfb_front.sv =====
module bmpfb_front import bmpfb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  logic                  req_start_of_file,
   input  logic                  queue_full,
   input  bmpfb_cfg_type         cfg,
   output logic                  push,
   output bmpfb_entry_type       push_entry
);

   logic                accept;
   logic                active_ff, active_in;
   logic [HDR_W-1:0]    hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]         raw_w_ff, raw_w_in;
   logic [31:0]         raw_h_ff, raw_h_in;
   logic [DIM_W-1:0]    img_w_ff, img_w_in;
   logic [DIM_W-1:0]    img_h_ff, img_h_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [COL_W-1:0]    frow_ff, frow_in;
   logic [1:0]          phase_ff, phase_in;
   logic [1:0]          pad_ff, pad_in;
   logic [BYTE_W-1:0]   blue_ff, blue_in;
   logic [BYTE_W-1:0]   green_ff, green_in;

   // working copies after a possible restart
   logic                act;
   logic [HDR_W-1:0]    hc;
   logic [COL_W-1:0]    col;
   logic [COL_W-1:0]    frow;
   logic [1:0]          ph;
   logic [1:0]          pad;
   logic [1:0]          sel;
   logic [31:0]         h_abs;
   logic                row_end;
   logic                img_last;

   assign accept = req_valid && !queue_full;

   // byte classification and counters
   always_comb begin
      active_in  = active_ff;
      hdr_cnt_in = hdr_cnt_ff;
      raw_w_in   = raw_w_ff;
      raw_h_in   = raw_h_ff;
      img_w_in   = img_w_ff;
      img_h_in   = img_h_ff;
      col_in     = col_ff;
      frow_in    = frow_ff;
      phase_in   = phase_ff;
      pad_in     = pad_ff;
      blue_in    = blue_ff;
      green_in   = green_ff;
      push       = 1'b0;
      push_entry = '0;
      act        = active_ff;
      hc         = hdr_cnt_ff;
      col        = col_ff;
      frow       = frow_ff;
      ph         = phase_ff;
      pad        = pad_ff;
      sel        = '0;
      h_abs      = raw_h_ff[31] ? (~raw_h_ff + 32'd1) : raw_h_ff;
      row_end    = ({1'b0, col_ff} == (img_w_ff - DIM_W'(1)));
      img_last   = 1'b0;

      if (accept) begin
         // start of file aborts any image in progress
         if (req_start_of_file) begin
            act  = 1'b1;
            hc   = '0;
            col  = '0;
            frow = '0;
            ph   = '0;
            pad  = '0;
         end
         active_in  = act;
         hdr_cnt_in = hc;
         col_in     = col;
         frow_in    = frow;
         phase_in   = ph;
         pad_in     = pad;
         row_end    = ({1'b0, col} == (img_w_ff - DIM_W'(1)));
         img_last   = row_end && ({1'b0, frow} == (img_h_ff - DIM_W'(1)));

         if (act) begin
            if (hc < HDR_W'(HDR_BYTES)) begin
               // header: capture width and height words
               if (hc >= HDR_W'(W_OFS) && hc < HDR_W'(W_OFS + 4)) begin
                  sel = 2'(hc - HDR_W'(W_OFS));
                  raw_w_in[8*sel +: 8] = req_data_byte;
               end else if (hc >= HDR_W'(H_OFS) && hc < HDR_W'(H_OFS + 4)) begin
                  sel = 2'(hc - HDR_W'(H_OFS));
                  raw_h_in[8*sel +: 8] = req_data_byte;
               end
               // settle dimensions: negative width is empty, height by magnitude
               if (hc == HDR_W'(DIM_AT)) begin
                  if (raw_w_ff[31]) begin
                     img_w_in = '0;
                  end else if (raw_w_ff > 32'(MAX_DIM)) begin
                     img_w_in = DIM_W'(MAX_DIM);
                  end else begin
                     img_w_in = raw_w_ff[DIM_W-1:0];
                  end
                  img_h_in = (h_abs > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : h_abs[DIM_W-1:0];
               end
               // last header byte: empty image ends here, else first row base
               if (hc == HDR_W'(HDR_BYTES - 1)) begin
                  if (img_w_ff == '0 || img_h_ff == '0) begin
                     active_in = 1'b0;
                  end else begin
                     push                  = 1'b1;
                     push_entry.new_row    = 1'b1;
                     push_entry.frame_row  = FROW_W'(cfg.top_row) + FROW_W'(img_h_ff)
                                             - FROW_W'(1);
                     push_entry.line_width = cfg.line_width;
                     push_entry.left_col   = cfg.left_col;
                  end
               end
               hdr_cnt_in = hc + HDR_W'(1);
            end else if (pad != 2'd0) begin
               // row padding
               pad_in = pad - 2'd1;
            end else begin
               // pixel bytes blue, green, red
               unique case (ph)
                  2'd0: begin
                     blue_in  = req_data_byte;
                     phase_in = 2'd1;
                  end
                  2'd1: begin
                     green_in = req_data_byte;
                     phase_in = 2'd2;
                  end
                  default: begin
                     phase_in              = 2'd0;
                     push                  = 1'b1;
                     push_entry.has_pixel  = 1'b1;
                     push_entry.column     = col;
                     push_entry.pixel      = {blue_ff, green_ff, req_data_byte};
                     push_entry.last       = img_last;
                     push_entry.line_width = cfg.line_width;
                     push_entry.left_col   = cfg.left_col;
                     if (img_last) begin
                        active_in = 1'b0;
                     end else if (row_end) begin
                        col_in               = '0;
                        frow_in              = frow + COL_W'(1);
                        pad_in               = img_w_ff[1:0];
                        push_entry.new_row   = 1'b1;
                        push_entry.frame_row = FROW_W'(cfg.top_row) + FROW_W'(img_h_ff)
                                               - FROW_W'(frow) - FROW_W'(2);
                     end else begin
                        col_in = col + COL_W'(1);
                     end
                  end
               endcase
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         hdr_cnt_ff <= '0;
         img_w_ff   <= '0;
         img_h_ff   <= '0;
         col_ff     <= '0;
         frow_ff    <= '0;
         phase_ff   <= '0;
         pad_ff     <= '0;
         raw_w_ff   <= '0;
         raw_h_ff   <= '0;
      end else begin
         active_ff  <= active_in;
         hdr_cnt_ff <= hdr_cnt_in;
         img_w_ff   <= img_w_in;
         img_h_ff   <= img_h_in;
         col_ff     <= col_in;
         frow_ff    <= frow_in;
         phase_ff   <= phase_in;
         pad_ff     <= pad_in;
         raw_w_ff   <= raw_w_in;
         raw_h_ff   <= raw_h_in;
      end
   end

   // colour holding
   always_ff @(posedge clock) begin
      blue_ff  <= blue_in;
      green_ff <= green_in;
   end

   // final pixel closes the image
   assert property (@(posedge clock) disable iff (reset)
      push && push_entry.last |=> !active_ff)
      else $error("image still active after its last pixel");

endmodule

// ===== design/bmpfb_queue.sv =====
module bmpfb_queue import bmpfb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bmpfb_entry_type  push_entry,
   input  logic             pop,
   output bmpfb_entry_type  pop_entry,
   output logic             full,
   output logic             empty
);

   bmpfb_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");

endmodule

// ===== design/bmpfb_back.sv =====
module bmpfb_back import bmpfb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  bmpfb_entry_type    head,
   input  logic               head_valid,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FBA_W-1:0]   rsp_fb_address,
   output logic [PIX_W-1:0]   rsp_pixel_value,
   output logic               rsp_outside,
   output logic               rsp_last_pixel
);

   logic                s1_valid_ff, s1_valid_in;
   bmpfb_stage_type     s1_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [ADDR_W-1:0]   row_addr_ff, row_addr_in;
   logic                out_valid_ff, out_valid_in;
   logic [FBA_W-1:0]    out_addr_ff;
   logic [PIX_W-1:0]    out_pixel_ff;
   logic                out_outside_ff;
   logic                out_last_ff;
   logic                out_free;
   logic                s1_go;
   logic                s1_ready;
   logic [ADDR_W-1:0]   pix_addr;

   // stage handshakes: row-only entries need no output slot
   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_go    = s1_valid_ff && (!s1_ff.has_pixel || out_free);
   assign s1_ready = !s1_valid_ff || s1_go;
   assign pop      = head_valid && s1_ready;

   // address of this pixel and next row base
   assign pix_addr = row_addr_ff + ADDR_W'(s1_ff.column);

   always_comb begin
      s1_valid_in  = s1_ready ? pop : s1_valid_ff;
      row_addr_in  = (s1_go && s1_ff.new_row) ?
                     ADDR_W'(prod_ff) + ADDR_W'(s1_ff.left_col) : row_addr_ff;
      if (s1_go && s1_ff.has_pixel) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // multiplier stage: framebuffer row times stride
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff.has_pixel <= head.has_pixel;
         s1_ff.new_row   <= head.new_row;
         s1_ff.left_col  <= head.left_col;
         s1_ff.column    <= head.column;
         s1_ff.pixel     <= head.pixel;
         s1_ff.last      <= head.last;
         prod_ff         <= PROD_W'(head.frame_row) * PROD_W'(head.line_width);
      end
   end

   // row base and output register
   always_ff @(posedge clock) begin
      row_addr_ff <= row_addr_in;
      if (s1_go && s1_ff.has_pixel) begin
         out_addr_ff    <= pix_addr[FBA_W-1:0];
         out_pixel_ff   <= s1_ff.pixel;
         out_outside_ff <= (pix_addr >= ADDR_W'(FB_WORDS));
         out_last_ff    <= s1_ff.last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_fb_address  = out_addr_ff;
   assign rsp_pixel_value = out_pixel_ff;
   assign rsp_outside     = out_outside_ff;
   assign rsp_last_pixel  = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_go && s1_ff.has_pixel))
      else $error("result raised without a pixel leaving the multiplier stage");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.has_pixel && !out_free |=> s1_valid_ff && $stable(s1_ff))
      else $error("pixel entry lost while output held");

endmodule

// ===== design/bmp24_to_framebuffer_writer_core.sv =====
// 24-bit bmp stream to framebuffer writes, one file byte per cycle while req_stall is low
// a pixel write passes the queue, the multiplier stage and the output register before rsp
// a four-entry queue lets bytes flow while a write is stalled
// the row base uses one 13x12 multiplier stage, needed at most once every three bytes
// reset: synchronous, clears counters and queue, idles until start_of_file; line_width 640
module bmp24_to_framebuffer_writer_core import bmpfb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_start_of_file,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [FBA_W-1:0]       rsp_fb_address,
   output logic [PIX_W-1:0]       rsp_pixel_value,
   output logic                   rsp_outside,
   output logic                   rsp_last_pixel,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   bmpfb_cfg_type     cfg_ff, cfg_in;
   logic              push;
   bmpfb_entry_type   push_entry;
   logic              pop;
   bmpfb_entry_type   head;
   logic              queue_full;
   logic              queue_empty;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TOP_ROW:    cfg_in.top_row    = csr_data[SROW_W-1:0];
            CSR_LEFT_COL:   cfg_in.left_col   = csr_data[SCOL_W-1:0];
            CSR_LINE_WIDTH: cfg_in.line_width = csr_data[LW_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.top_row    <= '0;
         cfg_ff.left_col   <= '0;
         cfg_ff.line_width <= LINE_WIDTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmpfb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_data_byte     (req_data_byte),
      .req_start_of_file (req_start_of_file),
      .queue_full        (queue_full),
      .cfg               (cfg_ff),
      .push              (push),
      .push_entry        (push_entry)
   );

   bmpfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   bmpfb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (!queue_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_fb_address  (rsp_fb_address),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_outside     (rsp_outside),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

// ===== test/bmp24_to_framebuffer_writer_core_test.sv =====
`timescale 1ns / 100ps

module bmp24_to_framebuffer_writer_core_test;
   import bmpfb_pkg::*;

   // one expected framebuffer write
   typedef struct packed {
      logic [FBA_W-1:0] fb_address;
      logic [PIX_W-1:0] pixel_value;
      logic             outside;
      logic             last_pixel;
   } fb_write_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_data_byte = '0;
   logic                  req_start_of_file = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [FBA_W-1:0]      rsp_fb_address;
   logic [PIX_W-1:0]      rsp_pixel_value;
   logic                  rsp_outside;
   logic                  rsp_last_pixel;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int writes_seen = 0;
   int outside_seen = 0;
   int ends_seen = 0;
   int reg_writes = 0;
   int bytes_decoded = 0;

   fb_write_type pending_writes[$];

   // shadow copy of the registers
   logic [SROW_W-1:0] cfg_top_row = '0;
   logic [SCOL_W-1:0] cfg_left_col = '0;
   logic [LW_W-1:0]   cfg_line_width = LINE_WIDTH_RST;

   // shadow copy of the decoder state
   int unsigned hdr_pos = 0;
   logic [11:0] img_w = '0;
   logic [11:0] img_h = '0;
   logic [11:0] col_pos = '0;
   logic [11:0] file_row = '0;
   logic [1:0]  colour_phase = '0;
   logic [1:0]  pad_left = '0;
   logic [7:0]  blue_byte = '0;
   logic [7:0]  green_byte = '0;
   logic [31:0] row_base_addr = '0;
   logic [31:0] raw_width = '0;
   logic [31:0] raw_height = '0;
   logic        image_on = 1'b0;

   bmp24_to_framebuffer_writer_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_start_of_file (req_start_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fb_address    (rsp_fb_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_outside       (rsp_outside),
      .rsp_last_pixel    (rsp_last_pixel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #4000000;
      $display("run limit reached with %0d pixel writes outstanding", pending_writes.size());
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [11:0] clamp_dim(input logic [31:0] v);
      return (v > 32'(MAX_DIM)) ? 12'(MAX_DIM) : v[11:0];
   endfunction

   function automatic logic [31:0] magnitude(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // framebuffer word of the first pixel of the current file row
   function automatic logic [31:0] frame_row_base();
      logic [31:0] frame_row;
      frame_row = 32'(cfg_top_row) + 32'(img_h) - 32'd1 - 32'(file_row);
      return frame_row * 32'(cfg_line_width) + 32'(cfg_left_col);
   endfunction

   // advance the shadow decoder by one accepted byte, queueing any pixel write
   function automatic void decode_byte(input logic [7:0] b, input logic sof);
      logic [31:0] addr;
      logic        is_last;
      if (sof) begin
         image_on = 1'b1;
         hdr_pos = 0;
         col_pos = '0;
         file_row = '0;
         colour_phase = '0;
         pad_left = '0;
         raw_width = '0;
         raw_height = '0;
      end
      if (!image_on) return;
      bytes_decoded++;

      // header: capture the dimension words, settle sizes on the last byte
      if (hdr_pos < HDR_BYTES) begin
         if (hdr_pos >= W_OFS && hdr_pos < W_OFS + 4)
            raw_width |= 32'(b) << (8 * (hdr_pos - W_OFS));
         else if (hdr_pos >= H_OFS && hdr_pos < H_OFS + 4)
            raw_height |= 32'(b) << (8 * (hdr_pos - H_OFS));
         if (hdr_pos == HDR_BYTES - 1) begin
            img_w = raw_width[31] ? 12'd0 : clamp_dim(raw_width);
            img_h = clamp_dim(magnitude(raw_height));
            if (img_w == 12'd0 || img_h == 12'd0)
               image_on = 1'b0;
            else
               row_base_addr = frame_row_base();
         end
         hdr_pos++;
         return;
      end

      // row padding
      if (pad_left != 2'd0) begin
         pad_left--;
         return;
      end

      // blue, green, then red completes a pixel
      if (colour_phase == 2'd0) begin
         blue_byte = b;
         colour_phase = 2'd1;
         return;
      end
      if (colour_phase == 2'd1) begin
         green_byte = b;
         colour_phase = 2'd2;
         return;
      end
      colour_phase = 2'd0;

      addr = row_base_addr + 32'(col_pos);
      is_last = (col_pos == img_w - 12'd1) && (file_row == img_h - 12'd1);
      pending_writes.push_back('{addr[FBA_W-1:0], {blue_byte, green_byte, b},
                                 addr >= 32'(FB_WORDS), is_last});

      if (is_last) begin
         image_on = 1'b0;
      end else if (col_pos == img_w - 12'd1) begin
         col_pos = '0;
         file_row++;
         pad_left = img_w[1:0];
         row_base_addr = frame_row_base();
      end else begin
         col_pos++;
      end
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // compare each accepted write with the oldest expected one
   always @(posedge clock) begin
      fb_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         writes_seen++;
         if (rsp_outside) outside_seen++;
         if (rsp_last_pixel) ends_seen++;
         if (pending_writes.size() == 0) begin
            $error("unexpected pixel write to %0h", rsp_fb_address);
            error_count++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_fb_address !== want.fb_address) begin
               $error("fb_address: expected %0h, got %0h", want.fb_address, rsp_fb_address);
               error_count++;
            end
            if (rsp_pixel_value !== want.pixel_value) begin
               $error("pixel_value: expected %0h, got %0h", want.pixel_value,
                      rsp_pixel_value);
               error_count++;
            end
            if (rsp_outside !== want.outside) begin
               $error("outside: expected %0b, got %0b", want.outside, rsp_outside);
               error_count++;
            end
            if (rsp_last_pixel !== want.last_pixel) begin
               $error("last_pixel: expected %0b, got %0b", want.last_pixel, rsp_last_pixel);
               error_count++;
            end
         end
      end
   end

   // one file byte, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b, input logic sof);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_start_of_file <= sof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b, sof);
   endtask

   // writes every register, holding valid across the three requests
   task automatic write_regs(input logic [SROW_W-1:0] srow, input logic [SCOL_W-1:0] scol,
                             input logic [LW_W-1:0] lw);
      logic [CSR_IDX_W-1:0]  idx[3];
      logic [CSR_DATA_W-1:0] vals[3];
      int k;
      idx = '{CSR_TOP_ROW, CSR_LEFT_COL, CSR_LINE_WIDTH};
      vals = '{CSR_DATA_W'(srow), CSR_DATA_W'(scol), CSR_DATA_W'(lw)};
      for (k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data <= vals[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cfg_top_row = srow;
      cfg_left_col = scol;
      cfg_line_width = lw;
      reg_writes += 3;
   endtask

   // stop sending, let every expected write arrive, then allow the pipeline to settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [7:0] pixel_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // a whole file: header, pixel body (optionally cut short), then stray bytes
   task automatic send_file(input logic [31:0] w_field, input logic [31:0] h_field,
                            input int body_cut, input int trail);
      int i;
      int body_len;
      logic [31:0] eff_w;
      logic [31:0] eff_h;
      logic [7:0] b;
      for (i = 0; i < HDR_BYTES; i++) begin
         if (i >= W_OFS && i < W_OFS + 4)
            b = w_field[8 * (i - W_OFS) +: 8];
         else if (i >= H_OFS && i < H_OFS + 4)
            b = h_field[8 * (i - H_OFS) +: 8];
         else
            b = 8'($urandom);
         send_byte(b, i == 0);
      end
      eff_w = w_field[31] ? 32'd0 : 32'(clamp_dim(w_field));
      eff_h = 32'(clamp_dim(magnitude(h_field)));
      body_len = int'((3 * eff_w + (eff_w % 4)) * eff_h);
      if (body_cut >= 0 && body_cut < body_len) body_len = body_cut;
      for (i = 0; i < body_len; i++) send_byte(pixel_byte(), 1'b0);
      for (i = 0; i < trail; i++) send_byte(8'($urandom), 1'b0);
   endtask

   // reset register values, and stray bytes before any start
   task automatic test_reset_config();
      repeat (4) send_byte(8'($urandom), 1'b0);
      send_file(32'd2, 32'd2, -1, 0);
      wait_quiet();
   endtask

   // every padding length, one to four pixels per row
   task automatic test_row_padding();
      int w;
      for (w = 1; w <= 4; w++) send_file(32'(w), 32'd2, -1, 2);
      wait_quiet();
   endtask

   // unusual header contents, restarts and trailing bytes
   task automatic test_header_cases();
      // negative width, zero width and zero height give empty images
      send_file(32'h8000_0005, 32'd2, -1, 3);
      send_file(32'd0, 32'd3, -1, 2);
      send_file(32'd3, 32'd0, -1, 2);
      // negative height is taken as its magnitude
      send_file(32'd2, 32'hFFFF_FFFD, -1, 1);
      // dimensions at or beyond the limit, each cut short by the next start
      send_file(32'h0000_0801, 32'd1, 30, 0);
      send_file(32'd1, 32'h8000_0000, 16, 0);
      send_file(32'd2, 32'h0000_0800, 20, 0);
      send_file(32'h0001_0000, 32'h0010_0000, 12, 0);
      // complete image followed by bytes that must be ignored
      send_file(32'd3, 32'd2, -1, 5);
      wait_quiet();
   endtask

   // register extremes, including addresses beyond the framebuffer
   task automatic test_register_extremes();
      write_regs(11'd2047, 11'd2047, 12'd2048);
      send_file(32'd3, 32'd2, -1, 0);
      wait_quiet();
      write_regs(11'd0, 11'd0, 12'd1);
      send_file(32'd4, 32'd3, -1, 0);
      wait_quiet();
      // top row just inside, bottom row just past the end
      write_regs(11'd2047, 11'd0, 12'd512);
      send_file(32'd5, 32'd2, -1, 0);
      wait_quiet();
      write_regs(11'd0, 11'd0, LINE_WIDTH_RST);
   endtask

   // random files under every idling mode and several register settings
   task automatic test_random_traffic();
      int mode;
      int phase_end;
      int pick;
      int w;
      int h;
      logic [31:0] hf;
      logic [SROW_W-1:0] srow;
      logic [SCOL_W-1:0] scol;
      logic [LW_W-1:0] lw;
      for (mode = 0; mode < 4; mode++) begin
         wait_quiet();
         case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 46; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 46; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         // new register setting, extremes now and then
         if ($urandom_range(0, 2) != 0) begin
            srow = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 11'd2047 : 11'd0)
                                               : 11'($urandom_range(0, 40));
            scol = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 11'd2047 : 11'd0)
                                               : 11'($urandom_range(0, 100));
            lw = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 12'd2048 : 12'd1)
                                             : 12'($urandom_range(1, 800));
            write_regs(srow, scol, lw);
         end
         phase_end = bytes_decoded + 40;
         while (bytes_decoded < phase_end) begin
            pick = $urandom_range(0, 99);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            h = $urandom_range(1, 4);
            hf = ($urandom_range(0, 4) == 0) ? (32'd0 - 32'(h)) : 32'(h);
            if (pick < 70) begin
               send_file(32'(w), hf, -1, $urandom_range(0, 4));
            end else if (pick < 80) begin
               // cut short, the next start aborts it
               send_file(32'(w), hf, $urandom_range(0, 3 * w * h), 0);
            end else if (pick < 88) begin
               case ($urandom_range(0, 2))
                  0: send_file(32'd0, hf, -1, 2);
                  1: send_file(32'(w), 32'd0, -1, 2);
                  default: send_file(32'h8000_0000 | 32'($urandom), hf, -1, 2);
               endcase
            end else begin
               // noise with occasional starts
               repeat ($urandom_range(20, 40))
                  send_byte(8'($urandom), $urandom_range(0, 19) == 0);
            end
            if ($urandom_range(0, 99) < 8) wait_quiet();
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_row_padding();
      test_header_cases();
      test_register_extremes();
      test_random_traffic();
      wait_quiet();
      $display("decoded %0d file bytes into %0d pixel writes, %0d outside, %0d image ends",
               bytes_decoded, writes_seen, outside_seen, ends_seen);
      $display("%0d register writes over four idling modes", reg_writes);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== bmp24_to_framebuffer_writer_core.f =====
design/bmpfb_pkg.sv
design/bmpfb_front.sv
design/bmpfb_queue.sv
design/bmpfb_back.sv
design/bmp24_to_framebuffer_writer_core.sv
test/bmp24_to_framebuffer_writer_core_test.sv
